// ===== src/fctc_pkg.sv =====
// ----------------------------------------------------------------------------
// fctc_pkg: shared types and constants of the frequency calibration block
// item layouts, register map, controller states and control bundles
// ----------------------------------------------------------------------------
`default_nettype none

package fctc_pkg;

   // table depth used when the top level is not told otherwise
   localparam int DEPTH_DEFAULT = 1024;

   localparam int FREQ_W = 16;
   localparam logic [FREQ_W-1:0] RESET_MHZ = 16'd1000;

   // register interface
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
   localparam logic [1:0] REG_VAR_SHIFT   = 2'd1;
   localparam logic [1:0] REG_SLOPE_SHIFT = 2'd2;

   // item kinds
   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_SET  = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [9:0]         entry_index;
      logic [FREQ_W-1:0]  freq_mhz;
      logic signed [31:0] slope_value;
      logic signed [31:0] offset_value;
      logic signed [31:0] reading;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [FREQ_W-1:0]  current_mhz;
      logic               table_empty;
   } rsp_type;

   typedef struct packed {
      logic [10:0] entry_count;
      logic [3:0]  var_shift;
      logic [3:0]  slope_shift;
   } cfg_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [31:0]       slope;
      logic [31:0]       offset;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_PRODUCT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic search_init;
      logic probe;
      logic step;
      logic fetch;
      logic product;
      logic finish;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic go_search;
      logic more;
      logic hit;
   } status_type;

endpackage

`default_nettype wire

// ===== src/freq_cal_table_correction.sv =====
// ----------------------------------------------------------------------------
// freq_cal_table_correction: frequency-dependent power reading correction
// piecewise linear calibration table with binary search and error register
// ----------------------------------------------------------------------------
// usage
//   req channel (valid/ready) carries one item of kind load, set or read
//   rsp channel (valid/ready) returns exactly one item per accepted item
//   apb-style port: entry_count at 0x0, var_shift at 0x4, slope_shift at 0x8
// sequencing
//   load and read items: result register loaded as the item is accepted, one item
//   per cycle while rsp_ready stays high; set items: each search step reads the
//   probed entry through the registered read port of the table memory and then
//   compares it, then one entry fetch, one 32x32 multiply and one add/shift step
//   no new item is taken while a set item is searching
// stall
//   the result register holds its item while rsp_ready is low; a new item is
//   taken in the same cycle that the waiting one leaves, else req_ready drops
// reset
//   synchronous, active high; state, rsp_valid and csr fields cleared, stored error 0,
//   active frequency 1000 MHz; table contents stay undefined until loaded
// ----------------------------------------------------------------------------
`default_nettype none

module freq_cal_table_correction #(
   parameter int TABLE_DEPTH = fctc_pkg::DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input items
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire fctc_pkg::req_type                req_data,
   // result items
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output fctc_pkg::rsp_type                     rsp_data,
   // configuration port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [fctc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [fctc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [fctc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                  csr_pready
);

   fctc_pkg::cfg_type    cfg;
   fctc_pkg::cmd_type    cmd;
   fctc_pkg::status_type status;

   // register file; the user must write it only while no item is in flight, the block does not enforce this
   fctc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // sequencing of accept, search steps, fetch, multiply and result post
   fctc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table memory, search bounds, error arithmetic and the result register
   fctc_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== src/fctc_csr.sv =====
// ----------------------------------------------------------------------------
// fctc_csr: configuration registers
// apb-style write and read of entry count and the two shift amounts
// ----------------------------------------------------------------------------
`default_nettype none

module fctc_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [fctc_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [fctc_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic      [fctc_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                      pready,
   output fctc_pkg::cfg_type                         cfg
);

   logic [10:0] entry_count_ff, entry_count_in;
   logic [3:0]  var_shift_ff, var_shift_in;
   logic [3:0]  slope_shift_ff, slope_shift_in;
   logic        wr_en;
   logic [1:0]  reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];

   always_comb begin
      entry_count_in = entry_count_ff;
      var_shift_in   = var_shift_ff;
      slope_shift_in = slope_shift_ff;
      prdata         = '0;
      unique case (reg_sel)
         fctc_pkg::REG_ENTRY_COUNT: begin
            prdata = {21'b0, entry_count_ff};
            if (wr_en) entry_count_in = pwdata[10:0];
         end
         fctc_pkg::REG_VAR_SHIFT: begin
            prdata = {28'b0, var_shift_ff};
            if (wr_en) var_shift_in = pwdata[3:0];
         end
         fctc_pkg::REG_SLOPE_SHIFT: begin
            prdata = {28'b0, slope_shift_ff};
            if (wr_en) slope_shift_in = pwdata[3:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         var_shift_ff   <= '0;
         slope_shift_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
         var_shift_ff   <= var_shift_in;
         slope_shift_ff <= slope_shift_in;
      end
   end

   assign cfg.entry_count = entry_count_ff;
   assign cfg.var_shift   = var_shift_ff;
   assign cfg.slope_shift = slope_shift_ff;

endmodule

`default_nettype wire

// ===== src/fctc_dp.sv =====
// ----------------------------------------------------------------------------
// fctc_dp: datapath of the calibration block
// table memory, search bounds, error multiply and shift, result register
// ----------------------------------------------------------------------------
`default_nettype none

module fctc_dp #(
   parameter int TABLE_DEPTH = fctc_pkg::DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fctc_pkg::req_type    req_data,
   input  wire fctc_pkg::cfg_type    cfg,
   input  wire fctc_pkg::cmd_type    cmd,
   output fctc_pkg::status_type      status,
   output fctc_pkg::rsp_type         rsp_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   fctc_pkg::entry_type mem [TABLE_DEPTH];
   fctc_pkg::entry_type rd_ff;
   fctc_pkg::rsp_type   rsp_ff, rsp_in;

   logic [AW-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [AW:0]    mid_sum;
   logic [AW-1:0]  cur, pick, rd_addr, wr_addr;
   logic [31:0]    idx_wide, count_wide, count_sat, hi_wide;
   logic           idx_ok, wr_en, rd_en;
   logic [fctc_pkg::FREQ_W-1:0] freq_ff, active_ff, active_in;
   logic signed [31:0] error_ff, error_in, err_new;
   logic [31:0]    xw, prod_ff, y_sum;
   logic [4:0]     shamt;

   // search midpoint and the entry one below it (held at 0 when the midpoint is 0)
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign cur     = mid_sum[AW:1];
   assign pick    = (cur != '0) ? cur - AW'(1) : '0;

   assign idx_wide   = 32'(req_data.entry_index);
   assign idx_ok     = idx_wide < 32'(TABLE_DEPTH);
   assign wr_addr    = idx_wide[AW-1:0];
   assign wr_en      = cmd.accept && (req_data.kind == fctc_pkg::KIND_LOAD) && idx_ok;
   assign rd_en      = cmd.probe || cmd.fetch;
   assign rd_addr    = cmd.fetch ? pick : cur;

   assign count_wide = 32'(cfg.entry_count);
   assign count_sat  = (count_wide > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : count_wide;
   assign hi_wide    = count_sat - 32'd1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= '{freq:   req_data.freq_mhz,
                           slope:  req_data.slope_value,
                           offset: req_data.offset_value};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.search_init) begin
         lo_in = '0;
         hi_in = hi_wide[AW-1:0];
      end else if (cmd.step) begin
         if (rd_ff.freq > freq_ff) hi_in = cur;
         else lo_in = cur + AW'(1);
      end
   end

   // error = (offset + slope * (f << vs)) >>> (vs + ss), 32-bit wrap
   assign xw      = {16'b0, freq_ff} << cfg.var_shift;
   assign y_sum   = rd_ff.offset + prod_ff;
   assign shamt   = {1'b0, cfg.var_shift} + {1'b0, cfg.slope_shift};
   assign err_new = $signed(y_sum) >>> shamt;

   always_ff @(posedge clock) begin
      if (cmd.accept) freq_ff <= req_data.freq_mhz;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.product) prod_ff <= rd_ff.slope * xw;
      if (cmd.load_out) rsp_ff <= rsp_in;
   end

   always_comb begin
      error_in  = error_ff;
      active_in = active_ff;
      rsp_in    = '{value: '0, current_mhz: active_ff, table_empty: 1'b0};
      if (cmd.finish) begin
         error_in  = err_new;
         active_in = freq_ff;
         rsp_in    = '{value: err_new, current_mhz: freq_ff, table_empty: 1'b0};
      end else begin
         case (req_data.kind)
            fctc_pkg::KIND_SET: begin
               // only reached here with no entries in use
               if (cmd.load_out) begin
                  error_in  = '0;
                  active_in = req_data.freq_mhz;
               end
               rsp_in = '{value: '0, current_mhz: req_data.freq_mhz, table_empty: 1'b1};
            end
            fctc_pkg::KIND_READ: begin
               rsp_in.value = req_data.reading - error_ff;
            end
            default: begin
               rsp_in.value = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_ff  <= '0;
         active_ff <= fctc_pkg::RESET_MHZ;
      end else begin
         error_ff  <= error_in;
         active_ff <= active_in;
      end
   end

   assign status.go_search = (req_data.kind == fctc_pkg::KIND_SET) && (cfg.entry_count != '0);
   assign status.more      = hi_ff > lo_ff;
   assign status.hit       = rd_ff.freq == freq_ff;
   assign rsp_data         = rsp_ff;

endmodule

`default_nettype wire

// ===== src/fctc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fctc_ctrl: controller of the calibration block
// handshakes, search sequencing and result slot ownership
// ----------------------------------------------------------------------------
`default_nettype none

module fctc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire fctc_pkg::status_type status,
   output fctc_pkg::cmd_type         cmd
);

   fctc_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fctc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         fctc_pkg::ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               cmd.accept = 1'b1;
               if (status.go_search) begin
                  cmd.search_init = 1'b1;
                  state_in        = fctc_pkg::ST_PROBE;
               end else begin
                  cmd.load_out = 1'b1;
               end
            end
         end
         fctc_pkg::ST_PROBE: begin
            if (status.more) begin
               cmd.probe = 1'b1;
               state_in  = fctc_pkg::ST_COMPARE;
            end else begin
               cmd.fetch = 1'b1;
               state_in  = fctc_pkg::ST_PRODUCT;
            end
         end
         fctc_pkg::ST_COMPARE: begin
            if (status.hit) begin
               cmd.fetch = 1'b1;
               state_in  = fctc_pkg::ST_PRODUCT;
            end else begin
               cmd.step = 1'b1;
               state_in = fctc_pkg::ST_PROBE;
            end
         end
         fctc_pkg::ST_PRODUCT: begin
            cmd.product = 1'b1;
            state_in    = fctc_pkg::ST_FINISH;
         end
         fctc_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               cmd.load_out = 1'b1;
               state_in     = fctc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fctc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.load_out;
   assign rsp_valid    = rsp_valid_ff;

`ifndef SYNTHESIS
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != fctc_pkg::ST_IDLE) |-> !req_ready)
      else $error("input taken while a search is in progress");

   a_compare_after_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fctc_pkg::ST_COMPARE) |-> ($past(state_ff) == fctc_pkg::ST_PROBE))
      else $error("compare without a table read in flight");

   a_product_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fctc_pkg::ST_PRODUCT) |->
         ($past(state_ff) == fctc_pkg::ST_PROBE || $past(state_ff) == fctc_pkg::ST_COMPARE))
      else $error("product without an entry fetch");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fctc_pkg::ST_FINISH && out_free) |=>
         (state_ff == fctc_pkg::ST_IDLE && rsp_valid_ff))
      else $error("set result not posted at finish");
`endif

endmodule

`default_nettype wire
